@@ hw/rtl/sws_pkg.sv @@
// Shared types and constants for the sliding-window k-smallest sum unit.
// No dependencies.
package sws_pkg;

  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 32;
  localparam int SAMPLE_W    = 32;
  localparam int CFG_W       = 7;
  localparam int SUM_W       = 38;
  localparam int AGE_W       = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int IDX_W       = AGE_W;
  localparam int WIN_W       = $clog2(WINDOW_MAX + 1);
  localparam int TREE_LEVELS = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int TREE_N      = 1 << TREE_LEVELS;
  localparam int CFG_IDX_W   = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LEN = 1'b0,
    REG_K_COUNT    = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORK,
    ST_LAUNCH
  } state_t;

  typedef struct packed {
    logic                   valid;
    logic [AGE_W-1:0]       age;
    logic [SAMPLE_BITS-1:0] value;
  } cell_t;

  typedef struct packed {
    logic                   age_step;
    logic                   compact;
    logic                   insert;
    logic [WIN_W-1:0]       win;
    logic [SAMPLE_BITS-1:0] sample;
  } cell_ctl_t;

endpackage

@@ hw/rtl/sws_cell.sv @@
// One cell of the sorted sample chain: value, age and valid bit.
// Ages and evicts, closes the first hole, inserts in order. Uses sws_pkg.
module sws_cell import sws_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  cell_t     right_q,
  input  cell_t     left_c,
  input  logic      left_e,
  input  logic      hole_in,
  output cell_t     q,
  output cell_t     c,
  output logic      e,
  output logic      hole_out
);

  logic                   valid;
  logic [AGE_W-1:0]       age;
  logic [SAMPLE_BITS-1:0] value;
  cell_t                  cell_next;
  logic [WIN_W-1:0]       age_inc;

  assign q        = '{valid: valid, age: age, value: value};
  assign hole_out = hole_in | ~valid;
  assign c        = hole_out ? right_q : q;
  assign e        = ~c.valid | (c.value > ctl.sample);
  assign age_inc  = WIN_W'(age) + WIN_W'(1);

  always_comb begin
    cell_next = q;
    if (ctl.age_step) begin
      cell_next.age = age_inc[AGE_W-1:0];
      if (age_inc >= ctl.win) begin
        cell_next.valid = 1'b0;
      end
    end else if (ctl.compact) begin
      if (ctl.insert && e && !left_e) begin
        cell_next = '{valid: 1'b1, age: '0, value: ctl.sample};
      end else if (ctl.insert && e) begin
        cell_next = left_c;
      end else begin
        cell_next = c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      age   <= '0;
    end else begin
      valid <= cell_next.valid;
      age   <= cell_next.age;
    end
  end

  always_ff @(posedge clk) begin
    value <= cell_next.value;
  end

endmodule

@@ hw/rtl/sws_sum_tree.sv @@
// Registered pairwise adder tree with one stall enable for the whole pipe.
// Last level is the output register. Uses sws_pkg.
module sws_sum_tree import sws_pkg::*; (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  load,
  input  logic [WINDOW_MAX-1:0][SAMPLE_BITS-1:0] leaf,
  output logic                                  adv,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [SUM_W-1:0]                      window_sum
);

  logic [TREE_N-1:0][SAMPLE_BITS-1:0] leaf_pad;
  logic [SUM_W-1:0]                   sum_q [1:TREE_LEVELS][TREE_N/2];
  logic [TREE_LEVELS:1]               vld;

  for (genvar g = 0; g < TREE_N; g++) begin : g_pad
    if (g < WINDOW_MAX) begin : g_leaf
      assign leaf_pad[g] = leaf[g];
    end else begin : g_zero
      assign leaf_pad[g] = '0;
    end
  end

  assign out_valid  = vld[TREE_LEVELS];
  assign adv        = ~vld[TREE_LEVELS] | out_ready;
  assign window_sum = sum_q[TREE_LEVELS][0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld[1] <= load;
      for (int l = 2; l <= TREE_LEVELS; l++) begin
        vld[l] <= vld[l-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < TREE_N / 2; i++) begin
        sum_q[1][i] <= SUM_W'(leaf_pad[2*i]) + SUM_W'(leaf_pad[2*i+1]);
      end
      for (int l = 2; l <= TREE_LEVELS; l++) begin
        for (int i = 0; i < (TREE_N >> l); i++) begin
          sum_q[l][i] <= sum_q[l-1][2*i] + sum_q[l-1][2*i+1];
        end
      end
    end
  end

endmodule

@@ hw/rtl/sliding_window_k_smallest_sum_unit.sv @@
// Sliding-window sum of the k smallest samples: a chain of 64 sorted cells
// feeding a registered adder tree. Uses sws_pkg, sws_cell, sws_sum_tree.
//
// In steady state a sample goes through these steps: the transfer edge ages every
// cell and drops the one leaving the window; in ST_WORK the cell chain then closes
// that hole and inserts the new sample in order; in ST_LAUNCH the rank-masked cell
// values go into a 6-level adder tree while the next sample is taken. When
// window_len is lowered, the first sample after stays in ST_WORK until every extra
// sample dropped has left no hole. A result is registered at each tree level up to
// the output register; the tree holds several results in flight and stalls as a
// whole when window_sum is not taken. No result until the window is full.
module sliding_window_k_smallest_sum_unit import sws_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [SAMPLE_W-1:0]  sample,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SUM_W-1:0]     window_sum
);

  logic [CFG_W-1:0]       window_len;
  logic [CFG_W-1:0]       k_count;
  logic [SAMPLE_BITS-1:0] sample_q;
  state_t                 state;
  state_t                 state_next;
  logic [WIN_W-1:0]       win;
  logic [WIN_W-1:0]       win_m1;
  logic                   accept;
  logic                   gap;
  logic                   full;
  logic                   adv;
  logic                   load;
  cell_ctl_t              ctl;

  cell_t [WINDOW_MAX-1:0]                cq;
  cell_t [WINDOW_MAX-1:0]                cc;
  cell_t [WINDOW_MAX-1:0]                right_q;
  cell_t [WINDOW_MAX-1:0]                left_c;
  logic  [WINDOW_MAX-1:0]                ce;
  logic  [WINDOW_MAX-1:0]                left_e;
  logic  [WINDOW_MAX-1:0]                hole_in;
  logic  [WINDOW_MAX-1:0]                hole_out;
  logic  [WINDOW_MAX-1:0]                valid_vec;
  logic  [WINDOW_MAX-1:0][SAMPLE_BITS-1:0] leaf;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= CFG_W'(64);
      k_count    <= CFG_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WINDOW_LEN: window_len <= cfg_data;
        REG_K_COUNT:    k_count    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (window_len == '0) begin
      win = WIN_W'(1);
    end else if (WIN_W'(window_len) > WIN_W'(WINDOW_MAX)) begin
      win = WIN_W'(WINDOW_MAX);
    end else begin
      win = WIN_W'(window_len);
    end
  end

  assign win_m1 = win - WIN_W'(1);
  assign accept = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q <= sample[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    gap = 1'b0;
    for (int i = 0; i < WINDOW_MAX - 1; i++) begin
      gap = gap | (~cc[i].valid & cc[i+1].valid);
    end
  end

  assign ctl = '{
    age_step: accept,
    compact:  (state == ST_WORK),
    insert:   (state == ST_WORK) & ~gap,
    win:      win,
    sample:   sample_q
  };

  for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign left_c[g]  = '0;
      assign left_e[g]  = 1'b0;
      assign hole_in[g] = 1'b0;
    end else begin : g_body
      assign left_c[g]  = cc[g-1];
      assign left_e[g]  = ce[g-1];
      assign hole_in[g] = hole_out[g-1];
    end
    if (g == WINDOW_MAX - 1) begin : g_tail
      assign right_q[g] = '0;
    end else begin : g_mid
      assign right_q[g] = cq[g+1];
    end

    sws_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .right_q  (right_q[g]),
      .left_c   (left_c[g]),
      .left_e   (left_e[g]),
      .hole_in  (hole_in[g]),
      .q        (cq[g]),
      .c        (cc[g]),
      .e        (ce[g]),
      .hole_out (hole_out[g])
    );

    assign valid_vec[g] = cq[g].valid;
    assign leaf[g] = (cq[g].valid && (g < int'(k_count))) ? cq[g].value : '0;
  end

  assign full = valid_vec[win_m1[IDX_W-1:0]];
  assign load = (state == ST_LAUNCH) & full & adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_WORK;
        end
      end
      ST_WORK: begin
        if (!gap) begin
          state_next = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        if (!full || adv) begin
          in_ready   = 1'b1;
          state_next = in_valid ? ST_WORK : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  sws_sum_tree u_tree (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .leaf       (leaf),
    .adv        (adv),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .window_sum (window_sum)
  );

endmodule
